// ===== src/wgts_pkg.sv =====
// ----------------------------------------------------------------------------
// wgts_pkg: shared types and constants for the winch gear / throttle block
// Field widths, gear codes, trim register indexes, queue sizing and the
// constant divider used by the trim maps.
// ----------------------------------------------------------------------------
package wgts_pkg;

  localparam int IN_W    = 16;
  localparam int PULSE_W = 12;
  localparam int TRIM_W  = 10;
  localparam int LIM_W   = 11;
  localparam int CNT_W   = 8;
  localparam int IDX_W   = 3;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int MUL_W   = 18;
  localparam int PROD_W  = 2 * MUL_W;

  // floor(n/125) = (n * RECIP_M) >> RECIP_S, exact for n < 493447
  localparam logic [MUL_W-1:0] RECIP_M = 18'd134218;
  localparam int RECIP_S = 24;

  localparam logic [IN_W-1:0]  WIDTH_MIN  = 16'd800;
  localparam logic [IN_W-1:0]  WIDTH_MAX  = 16'd2200;
  localparam logic [IN_W-1:0]  HOLD_LEVEL = 16'd1700;
  localparam logic [IN_W-1:0]  THR_HIGH   = 16'd1500;
  localparam logic [LIM_W-1:0] THR_LOW    = 11'd1000;
  localparam logic [CNT_W-1:0] HOLD_LONG  = 8'd40;
  localparam logic [CNT_W-1:0] HOLD_SHORT = 8'd4;
  localparam logic [CNT_W-1:0] HOLD_SAT   = 8'd255;

  localparam logic [TRIM_W-1:0] TRIM_RESET = 10'd512;

  localparam logic [IDX_W-1:0] REG_GEAR_REVERSE = 3'd0;
  localparam logic [IDX_W-1:0] REG_GEAR_NEUTRAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_GEAR_FORWARD = 3'd2;
  localparam logic [IDX_W-1:0] REG_ENGINE_STOP  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ENGINE_FULL  = 3'd4;

  typedef enum logic [1:0] {
    GEAR_FORWARD = 2'd0,
    GEAR_NEUTRAL = 2'd1,
    GEAR_REVERSE = 2'd2
  } gear_t;

  typedef struct packed {
    logic [LIM_W-1:0] lim;
    gear_t            gear;
  } item_t;

  typedef struct packed {
    logic [TRIM_W-1:0] gear_reverse;
    logic [TRIM_W-1:0] gear_neutral;
    logic [TRIM_W-1:0] gear_forward;
    logic [TRIM_W-1:0] engine_stop;
    logic [TRIM_W-1:0] engine_full;
  } trims_t;

  // floor(p / 1023) for p < 2^21 by two folding steps and one correction
  function automatic logic [LIM_W-1:0] div1023(input logic [20:0] p);
    logic [10:0] q0;
    logic [11:0] r;
    logic [1:0]  q1;
    logic [10:0] r2;
    q0 = p[20:10];
    r  = {2'b00, p[9:0]} + {1'b0, q0};
    q1 = r[11:10];
    r2 = {1'b0, r[9:0]} + {9'd0, q1};
    div1023 = q0 + {9'd0, q1} + ((r2 >= 11'd1023) ? 11'd1 : 11'd0);
  endfunction

endpackage

// ===== src/winch_gear_tip_select_and_throttle_map.sv =====
// ----------------------------------------------------------------------------
// winch_gear_tip_select_and_throttle_map: gear tip selection and throttle map
// Top level: trim registers, front classifier, queue and pulse sequencer.
// ----------------------------------------------------------------------------
// Each in-range throttle width (800..2200 us) yields one transaction with the
// throttle pulse, gear pulse and gear; out-of-range widths are dropped with
// no result. The front takes one width per cycle, while the queue has room,
// into a two-entry queue; the back computes each result with its sequencer
// issuing seven products in turn through one shared 18x18 multiplier, and
// takes a new transaction only once the last one is in its output register.
// Trim registers are written through the cfg port (always ready) and must
// only change while no transaction is in flight.
module winch_gear_tip_select_and_throttle_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wgts_pkg::IN_W-1:0]     in_pulse_width_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wgts_pkg::PULSE_W-1:0]  out_throttle_pulse_us,
  output logic [wgts_pkg::PULSE_W-1:0]  out_gear_pulse_us,
  output logic [1:0]                    out_gear_state,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wgts_pkg::IDX_W-1:0]    cfg_index,
  input  logic [wgts_pkg::TRIM_W-1:0]   cfg_data
);
  import wgts_pkg::*;

  trims_t trims_r;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  item_t  push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trims_r <= '{TRIM_RESET, TRIM_RESET, TRIM_RESET, TRIM_RESET, TRIM_RESET};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GEAR_REVERSE: trims_r.gear_reverse <= cfg_data;
        REG_GEAR_NEUTRAL: trims_r.gear_neutral <= cfg_data;
        REG_GEAR_FORWARD: trims_r.gear_forward <= cfg_data;
        REG_ENGINE_STOP:  trims_r.engine_stop  <= cfg_data;
        REG_ENGINE_FULL:  trims_r.engine_full  <= cfg_data;
        default: ;
      endcase
    end
  end

  wgts_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pulse_width_us (in_pulse_width_us),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_item         (push_item)
  );

  wgts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  wgts_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .trims                 (trims_r),
    .pop_valid             (pop_valid),
    .pop_ready             (pop_ready),
    .pop_item              (pop_item),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_throttle_pulse_us (out_throttle_pulse_us),
    .out_gear_pulse_us     (out_gear_pulse_us),
    .out_gear_state        (out_gear_state)
  );

endmodule

// ===== src/wgts_front.sv =====
// ----------------------------------------------------------------------------
// wgts_front: input range check and gear selection
// Drops out-of-range widths, tracks the stick hold and updates the gear,
// then pushes the clipped width and the new gear into the queue.
// ----------------------------------------------------------------------------
module wgts_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [wgts_pkg::IN_W-1:0]  in_pulse_width_us,
  output logic                       push_valid,
  input  logic                       push_ready,
  output wgts_pkg::item_t            push_item
);
  import wgts_pkg::*;

  gear_t            gear_r, gear_nxt;
  logic [CNT_W-1:0] hold_count_r, hold_count_nxt, count_inc;
  logic             hold_active_r, hold_active_nxt;
  logic             in_range, take;

  assign in_range = (in_pulse_width_us >= WIDTH_MIN) && (in_pulse_width_us <= WIDTH_MAX);
  assign in_ready = push_ready;
  assign take     = in_valid && push_ready && in_range;
  assign count_inc = (hold_count_r != HOLD_SAT) ? hold_count_r + 8'd1 : hold_count_r;

  always_comb begin
    gear_nxt        = gear_r;
    hold_count_nxt  = hold_count_r;
    hold_active_nxt = hold_active_r;
    if (in_pulse_width_us > HOLD_LEVEL) begin
      hold_count_nxt  = count_inc;
      hold_active_nxt = 1'b1;
      if (count_inc > HOLD_LONG) gear_nxt = GEAR_NEUTRAL;
    end else if (hold_active_r) begin
      // short tip toggles; neutral tips into forward
      if (hold_count_r > HOLD_SHORT && hold_count_r < HOLD_LONG)
        gear_nxt = (gear_r == GEAR_FORWARD) ? GEAR_REVERSE : GEAR_FORWARD;
      hold_active_nxt = 1'b0;
      hold_count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r        <= GEAR_NEUTRAL;
      hold_count_r  <= '0;
      hold_active_r <= 1'b0;
    end else if (take) begin
      gear_r        <= gear_nxt;
      hold_count_r  <= hold_count_nxt;
      hold_active_r <= hold_active_nxt;
    end
  end

  assign push_valid     = in_valid && in_range;
  assign push_item.lim  = (in_pulse_width_us > THR_HIGH) ? THR_HIGH[LIM_W-1:0]
                                                         : in_pulse_width_us[LIM_W-1:0];
  assign push_item.gear = gear_nxt;

endmodule

// ===== src/wgts_queue.sv =====
// ----------------------------------------------------------------------------
// wgts_queue: short FIFO between front and back
// Register-based ring of QDEPTH entries with push and pop handshakes.
// ----------------------------------------------------------------------------
module wgts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  wgts_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wgts_pkg::item_t pop_item
);
  import wgts_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QDEPTH[QCNT_W-1:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    bump = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH[QCNT_W-1:0])
    else $error("queue count beyond depth");

endmodule

// ===== src/wgts_back.sv =====
// ----------------------------------------------------------------------------
// wgts_back: pulse computation sequencer
// Works one queued transaction at a time through a shared multiplier:
// five trim maps, the throttle span product and a reciprocal divide.
// ----------------------------------------------------------------------------
module wgts_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wgts_pkg::trims_t             trims,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  wgts_pkg::item_t              pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wgts_pkg::PULSE_W-1:0] out_throttle_pulse_us,
  output logic [wgts_pkg::PULSE_W-1:0] out_gear_pulse_us,
  output logic [1:0]                   out_gear_state
);
  import wgts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FWD, ST_REV, ST_NEU, ST_STOP, ST_FULL,
    ST_SPAN, ST_DIFF, ST_MAG, ST_RECIP, ST_DONE
  } step_t;

  step_t              state_r;
  gear_t              gear_r;
  logic [8:0]         x_mag_r;
  logic               x_neg_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PULSE_W-1:0] hi_r, lo_r, neu_r, stop_r, full_r, gpulse_r;
  logic [LIM_W-1:0]   span_mag_r;
  logic               span_neg_r;
  logic [LIM_W-1:0]   dq, q;
  logic [PULSE_W:0]   diff;
  logic               out_valid_r;
  logic [PULSE_W-1:0] thr_out_r, gear_out_r;
  gear_t              gear_state_r;
  logic               finish;

  assign dq       = div1023(prod_r[20:0]);
  assign q        = prod_r[RECIP_S+LIM_W-1:RECIP_S];
  assign diff     = {1'b0, stop_r} - {1'b0, full_r};
  assign pop_ready = (state_r == ST_IDLE);
  assign finish   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_FWD:   begin mul_a = MUL_W'(trims.gear_forward); mul_b = 18'd700;  end
      ST_REV:   begin mul_a = MUL_W'(trims.gear_reverse); mul_b = 18'd700;  end
      ST_NEU:   begin mul_a = MUL_W'(trims.gear_neutral); mul_b = 18'd600;  end
      ST_STOP:  begin mul_a = MUL_W'(trims.engine_stop);  mul_b = 18'd1600; end
      ST_FULL:  begin mul_a = MUL_W'(trims.engine_full);  mul_b = 18'd600;  end
      ST_MAG:   begin mul_a = MUL_W'(x_mag_r); mul_b = MUL_W'(span_mag_r); end
      // /500 = /4 then /125
      ST_RECIP: begin mul_a = prod_r[MUL_W+1:2]; mul_b = RECIP_M; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (finish)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // hold the quotient until the output register frees up
      if (state_r != ST_DONE) prod_r <= prod_nxt;
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            gear_r  <= pop_item.gear;
            x_neg_r <= (pop_item.lim < THR_LOW);
            x_mag_r <= (pop_item.lim < THR_LOW) ? 9'(THR_LOW - pop_item.lim)
                                                : 9'(pop_item.lim - THR_LOW);
            state_r <= ST_FWD;
          end
        end
        ST_FWD:  state_r <= ST_REV;
        ST_REV: begin
          hi_r    <= 12'd1500 + {1'b0, dq};
          state_r <= ST_NEU;
        end
        ST_NEU: begin
          lo_r    <= 12'd1500 - {1'b0, dq};
          state_r <= ST_STOP;
        end
        ST_STOP: begin
          neu_r   <= 12'd1200 + {1'b0, dq};
          state_r <= ST_FULL;
        end
        ST_FULL: begin
          stop_r  <= 12'd800 + {1'b0, dq};
          state_r <= ST_SPAN;
        end
        ST_SPAN: begin
          full_r  <= 12'd1600 + {1'b0, dq};
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          span_neg_r <= diff[PULSE_W];
          span_mag_r <= diff[PULSE_W] ? LIM_W'(-diff) : LIM_W'(diff);
          case (gear_r)
            GEAR_FORWARD: gpulse_r <= hi_r;
            GEAR_REVERSE: gpulse_r <= lo_r;
            default: begin
              if (neu_r < lo_r)      gpulse_r <= lo_r;
              else if (neu_r > hi_r) gpulse_r <= hi_r;
              else                   gpulse_r <= neu_r;
            end
          endcase
          state_r <= ST_MAG;
        end
        ST_MAG:   state_r <= ST_RECIP;
        ST_RECIP: state_r <= ST_DONE;
        ST_DONE: begin
          if (finish) begin
            thr_out_r    <= (x_neg_r ^ span_neg_r) ? full_r - {1'b0, q}
                                                   : full_r + {1'b0, q};
            gear_out_r   <= gpulse_r;
            gear_state_r <= gear_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_throttle_pulse_us = thr_out_r;
  assign out_gear_pulse_us     = gear_out_r;
  assign out_gear_state        = gear_state_r;

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (gear_out_r >= 12'd800 && gear_out_r <= 12'd2200))
    else $error("gear pulse out of range");

  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (thr_out_r >= 12'd200 && thr_out_r <= 12'd3600))
    else $error("throttle pulse out of range");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished transaction not presented");

  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (state_r == ST_FWD))
    else $error("popped transaction not started");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for winch_gear_tip_select_and_throttle_map
// Drives throttle widths and trim writes. A behavioral predictor of the gear
// tip logic and the servo maps queues the expected commands. Every output
// transaction is checked against the oldest of them; most phases add random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import wgts_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_STALL   = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;
  localparam int TRIM_TOP     = 1023;
  localparam int NUM_TRIMS    = int'(REG_ENGINE_FULL) + 1;

  typedef struct packed {
    logic [PULSE_W-1:0] throttle;
    logic [PULSE_W-1:0] gear_pulse;
    gear_t              gear;
  } servo_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [IN_W-1:0]    in_pulse_width_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PULSE_W-1:0] out_throttle_pulse_us;
  logic [PULSE_W-1:0] out_gear_pulse_us;
  logic [1:0]         out_gear_state;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [TRIM_W-1:0]  cfg_data = '0;

  // predictor state
  logic [TRIM_W-1:0]  trim_m [NUM_TRIMS];
  gear_t              gear_m = GEAR_NEUTRAL;
  logic [CNT_W-1:0]   hold_cnt_m = '0;
  logic               holding_m = 1'b0;
  servo_cmd_t         pending_cmds [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic long_stall_req = 1'b0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  winch_gear_tip_select_and_throttle_map dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pulse_width_us     (in_pulse_width_us),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_throttle_pulse_us (out_throttle_pulse_us),
    .out_gear_pulse_us     (out_gear_pulse_us),
    .out_gear_state        (out_gear_state),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("winch_gear_tip_select_and_throttle_map: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int lin_scale(int x, int a, int b, int c, int d);
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  function automatic int trim_scale(logic [TRIM_W-1:0] t, int lo, int hi);
    return lin_scale(int'(t), 0, TRIM_TOP, lo, hi);
  endfunction

  task automatic predict_width(input logic [IN_W-1:0] w);
    int fwd, rev, neu, gp, lim, full_pt, stop_pt, thr;
    servo_cmd_t cmd;
    if (w < WIDTH_MIN || w > WIDTH_MAX) return;
    if (w > HOLD_LEVEL) begin
      if (hold_cnt_m != HOLD_SAT) hold_cnt_m++;
      if (hold_cnt_m > HOLD_LONG) gear_m = GEAR_NEUTRAL;
      holding_m = 1'b1;
    end else if (holding_m) begin
      // short tip toggles; neutral always goes to forward
      if (hold_cnt_m > HOLD_SHORT && hold_cnt_m < HOLD_LONG)
        gear_m = (gear_m == GEAR_FORWARD) ? GEAR_REVERSE : GEAR_FORWARD;
      holding_m = 1'b0;
      hold_cnt_m = '0;
    end
    fwd = trim_scale(trim_m[REG_GEAR_FORWARD], 1500, 2200);
    rev = trim_scale(trim_m[REG_GEAR_REVERSE], 1500, 800);
    neu = trim_scale(trim_m[REG_GEAR_NEUTRAL], 1200, 1800);
    case (gear_m)
      GEAR_FORWARD: gp = fwd;
      GEAR_REVERSE: gp = rev;
      default: begin
        if (neu < rev) gp = rev;
        else if (neu > fwd) gp = fwd;
        else gp = neu;
      end
    endcase
    lim = (w > THR_HIGH) ? int'(THR_HIGH) : int'(w);
    full_pt = trim_scale(trim_m[REG_ENGINE_FULL], 1600, 2200);
    stop_pt = trim_scale(trim_m[REG_ENGINE_STOP], 800, 2400);
    thr = lin_scale(lim, int'(THR_LOW), int'(THR_HIGH), full_pt, stop_pt);
    cmd.throttle = thr[PULSE_W-1:0];
    cmd.gear_pulse = gp[PULSE_W-1:0];
    cmd.gear = gear_m;
    pending_cmds.push_back(cmd);
  endtask

  // ------------------------------------------------------------------ checker
  task automatic check_result();
    servo_cmd_t want;
    if (pending_cmds.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("[%0t] unexpected transaction: throttle %0d gear pulse %0d gear %0d",
                 $time, out_throttle_pulse_us, out_gear_pulse_us, out_gear_state);
      return;
    end
    want = pending_cmds.pop_front();
    if (out_throttle_pulse_us !== want.throttle || out_gear_pulse_us !== want.gear_pulse ||
        out_gear_state !== want.gear) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("[%0t] throttle exp %0d got %0d, gear pulse exp %0d got %0d, gear exp %0d got %0d",
                 $time, want.throttle, out_throttle_pulse_us, want.gear_pulse,
                 out_gear_pulse_us, want.gear, out_gear_state);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers
  // entered and left at a falling edge
  task automatic send_width(input logic [IN_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pulse_width_us = w;
    do @(posedge clk); while (!in_ready);
    predict_width(w);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_trim(input logic [IDX_W-1:0] idx, input logic [TRIM_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_ENGINE_FULL) trim_m[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // dropped widths give no transaction, so allow the back end time to settle
  task automatic wait_idle();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_trims(input logic [TRIM_W-1:0] rev, neu, fwd, stp, ful);
    wait_idle();
    write_trim(REG_GEAR_REVERSE, rev);
    write_trim(REG_GEAR_NEUTRAL, neu);
    write_trim(REG_GEAR_FORWARD, fwd);
    write_trim(REG_ENGINE_STOP, stp);
    write_trim(REG_ENGINE_FULL, ful);
  endtask

  function automatic logic [IN_W-1:0] stray_width();
    if ($urandom_range(1) != 0) return IN_W'($urandom_range(WIDTH_MIN - 1));
    return IN_W'($urandom_range(16'hFFFF, WIDTH_MAX + 1));
  endfunction

  // len widths above the hold level, with occasional stray widths between them, then one release width
  task automatic send_hold_run(input int len);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) send_width(stray_width());
      send_width(IN_W'($urandom_range(WIDTH_MAX, HOLD_LEVEL + 1)));
    end
    send_width(IN_W'($urandom_range(HOLD_LEVEL, WIDTH_MIN)));
  endtask

  // walks through forward, reverse and neutral under the current trims
  task automatic cycle_gears();
    send_width(WIDTH_MIN);
    send_hold_run(HOLD_SHORT + 1);
    send_width(THR_HIGH);
    send_hold_run(HOLD_SHORT + 1);
    send_width(WIDTH_MAX);
    send_width(HOLD_LEVEL);
    send_hold_run(HOLD_LONG + 1);
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_width_edges();
    logic [IN_W-1:0] widths [$];
    widths = '{16'd0, 16'd799, 16'd800, 16'd801, 16'd999, 16'd1000, 16'd1001,
               16'd1499, 16'd1500, 16'd1501, 16'd1700, 16'd1701, 16'd1700,
               16'd2200, 16'd2201, 16'hFFFF, 16'h8000, 16'h7FFF};
    foreach (widths[i]) send_width(widths[i]);
  endtask

  task automatic test_gear_tips();
    int runs [$];
    runs = '{5, 5, 5, 4, 3, 39, 40, 41, 5, 1, 6};
    send_width(16'd1000);
    foreach (runs[i]) send_hold_run(runs[i]);
  endtask

  task automatic test_hold_saturation();
    send_hold_run(HOLD_SHORT + 1);
    send_hold_run(260);
    send_hold_run(HOLD_SHORT + 1);
  endtask

  task automatic test_stall_and_drain();
    long_stall_req = 1'b1;
    repeat (16) send_width(IN_W'($urandom_range(WIDTH_MAX, WIDTH_MIN)));
    wait_idle();
  endtask

  task automatic test_trim_extremes();
    load_trims(0, 0, 0, 0, 0);
    cycle_gears();
    load_trims(TRIM_TOP, TRIM_TOP, TRIM_TOP, TRIM_TOP, TRIM_TOP);
    cycle_gears();
    load_trims(TRIM_TOP, TRIM_TOP, 0, 0, TRIM_TOP);
    cycle_gears();
    load_trims(0, 0, TRIM_TOP, TRIM_TOP, 0);
    cycle_gears();
    load_trims(TRIM_TOP, 0, TRIM_TOP, TRIM_RESET, TRIM_RESET);
    cycle_gears();
  endtask

  // writes to unused indexes must leave every trim alone; the gear sits in
  // neutral here, so each width shows all five trims
  task automatic test_bad_index();
    wait_idle();
    for (int i = NUM_TRIMS; i < (1 << IDX_W); i++)
      write_trim(IDX_W'(i), TRIM_W'($urandom_range(TRIM_TOP)));
    repeat (8) send_width(IN_W'($urandom_range(HOLD_LEVEL, WIDTH_MIN)));
  endtask

  task automatic test_random_traffic(input int n);
    int sent, pick, len;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(9);
        if (pick < 2) len = $urandom_range(6, 3);
        else if (pick < 4) len = $urandom_range(42, 38);
        else if (pick == 4) len = $urandom_range(80, 43);
        else len = $urandom_range(37, 1);
        send_hold_run(len);
        sent += len + 1;
      end else if (pick < 92) begin
        send_width(IN_W'($urandom_range(HOLD_LEVEL, WIDTH_MIN)));
        sent++;
      end else begin
        send_width(stray_width());
      end
    end
  endtask

  task automatic load_random_trims();
    load_trims(TRIM_W'($urandom_range(TRIM_TOP)), TRIM_W'($urandom_range(TRIM_TOP)),
               TRIM_W'($urandom_range(TRIM_TOP)), TRIM_W'($urandom_range(TRIM_TOP)),
               TRIM_W'($urandom_range(TRIM_TOP)));
  endtask

  initial begin
    for (int i = 0; i < NUM_TRIMS; i++) trim_m[i] = TRIM_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 86;
    test_width_edges();
    test_gear_tips();
    test_hold_saturation();
    test_stall_and_drain();
    load_random_trims();
    test_random_traffic(20);

    send_idle_pct = 86;
    recv_idle_pct = 22;
    test_trim_extremes();
    test_bad_index();
    load_random_trims();
    test_random_traffic(20);
    test_stall_and_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_trims(TRIM_RESET, TRIM_RESET, TRIM_RESET, TRIM_RESET, TRIM_RESET);
    test_random_traffic(60);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("winch_gear_tip_select_and_throttle_map: match");
    end else begin
      $display("winch_gear_tip_select_and_throttle_map: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wgts_pkg.sv
src/wgts_front.sv
src/wgts_queue.sv
src/wgts_back.sv
src/winch_gear_tip_select_and_throttle_map.sv
tb/tb.sv
